/* rtl/core/dfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dfc_pkg;

  localparam int LINE_CHARS = 63;
  localparam int CNT_W      = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W     = $clog2(LINE_CHARS);
  localparam int MASK_W     = 64;
  localparam int IDX_W      = $clog2(MASK_W);
  localparam int QDEPTH     = 4;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] TAB_BYTE     = 8'd9;

  // configuration register indexes
  localparam logic [1:0] REG_SELECT_MASK    = 2'd0;
  localparam logic [1:0] REG_SEPARATOR      = 2'd1;
  localparam logic [1:0] REG_SUPPRESS_EMPTY = 2'd2;
  localparam logic [1:0] REG_BY_CHARACTER   = 2'd3;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_CLOSE  = 2'd1;
  localparam logic [1:0] CMD_REPLAY = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] select_mask;
    logic [7:0]        separator;
    logic              suppress_empty;
    logic              by_character;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             done;
    logic             err;
    logic             has_byte;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic replay_done;
  } back_status_t;

endpackage

`default_nettype wire

/* rtl/core/dfc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dfc_cut_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_done;
  logic       line_error;

  modport source (output valid, output out_byte, output line_done, output line_error,
                  input ready);
  modport sink   (input valid, input out_byte, input line_done, input line_error,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/dfc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfc_front (
  input  wire                  clk,
  input  wire                  rst,
  dfc_byte_if.sink             text_in,
  input  dfc_pkg::cfg_t        cfg,
  input  dfc_pkg::back_status_t back_status,
  input  wire                  q_full,
  output logic                 q_push,
  output dfc_pkg::cmd_t        q_data,
  output dfc_pkg::store_wr_t   store_wr
);
  import dfc_pkg::*;

  logic [CNT_W-1:0] char_count, char_count_next;
  logic [IDX_W-1:0] field_count, field_count_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic             any_selected, any_selected_next;
  logic             discarding, discarding_next;
  logic             replay_wait, replay_wait_next;
  logic             accept;
  logic [7:0]       b;
  logic [IDX_W-1:0] idx;

  // hold off while the queue is full or the back end replays the store
  assign text_in.ready = !q_full && !replay_wait;
  assign accept = text_in.valid && text_in.ready;
  assign b = text_in.in_byte;
  assign idx = cfg.by_character ? IDX_W'(char_count) : field_count;

  always_comb begin
    char_count_next   = char_count;
    field_count_next  = field_count;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    any_selected_next = any_selected;
    discarding_next   = discarding;
    replay_wait_next  = replay_wait;
    q_push            = 1'b0;
    q_data            = '0;
    store_wr          = '0;

    if (back_status.replay_done) begin
      replay_wait_next = 1'b0;
    end

    if (accept) begin
      if (discarding) begin
        if (b == NEWLINE_BYTE) begin
          discarding_next = 1'b0;
        end
      end else if (b == NEWLINE_BYTE) begin
        if (any_selected) begin
          q_push        = 1'b1;
          q_data.kind   = CMD_CLOSE;
          q_data.data   = held_byte;
          // a trailing separator is dropped
          q_data.has_byte = held_valid && (held_byte != cfg.separator);
        end else if (!cfg.suppress_empty && !cfg.by_character) begin
          q_push           = 1'b1;
          q_data.kind      = CMD_REPLAY;
          q_data.count     = char_count;
          replay_wait_next = 1'b1;
        end
        char_count_next   = '0;
        field_count_next  = '0;
        held_byte_next    = '0;
        held_valid_next   = 1'b0;
        any_selected_next = 1'b0;
      end else if (char_count >= CNT_W'(LINE_CHARS)) begin
        q_push            = 1'b1;
        q_data.kind       = CMD_BYTE;
        q_data.data       = '0;
        q_data.done       = 1'b1;
        q_data.err        = 1'b1;
        char_count_next   = '0;
        field_count_next  = '0;
        held_byte_next    = '0;
        held_valid_next   = 1'b0;
        any_selected_next = 1'b0;
        discarding_next   = 1'b1;
      end else begin
        store_wr.en   = 1'b1;
        store_wr.addr = char_count[ADDR_W-1:0];
        store_wr.data = b;
        if (cfg.select_mask[idx]) begin
          if (held_valid) begin
            q_push      = 1'b1;
            q_data.kind = CMD_BYTE;
            q_data.data = held_byte;
          end
          held_byte_next    = b;
          held_valid_next   = 1'b1;
          any_selected_next = 1'b1;
        end
        if (b == cfg.separator) begin
          field_count_next = field_count + 1'b1;
        end
        char_count_next = char_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      field_count  <= '0;
      held_byte    <= '0;
      held_valid   <= 1'b0;
      any_selected <= 1'b0;
      discarding   <= 1'b0;
      replay_wait  <= 1'b0;
    end else begin
      char_count   <= char_count_next;
      field_count  <= field_count_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      any_selected <= any_selected_next;
      discarding   <= discarding_next;
      replay_wait  <= replay_wait_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dfc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfc_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  dfc_pkg::cmd_t push_data,
  output logic          full,
  input  wire           pop,
  output dfc_pkg::cmd_t pop_data,
  output logic          empty
);
  import dfc_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t               slots [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     fill;
  logic               do_push, do_pop;

  assign full     = (fill == (PTR_W + 1)'(QDEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dfc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfc_back (
  input  wire                   clk,
  input  wire                   rst,
  input  dfc_pkg::store_wr_t    store_wr,
  input  wire                   q_empty,
  input  dfc_pkg::cmd_t         q_data,
  output logic                  q_pop,
  output dfc_pkg::back_status_t back_status,
  dfc_cut_if.source             cut_out
);
  import dfc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ONE   = 3'd1;
  localparam logic [2:0] S_HELD  = 3'd2;
  localparam logic [2:0] S_NL    = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  logic [7:0]       mem [LINE_CHARS];
  logic [7:0]       rd_data;
  logic             rd_en;

  logic [2:0]       state, state_next;
  cmd_t             cmd, cmd_next;
  logic [CNT_W-1:0] idx, idx_next;

  logic             out_valid, out_valid_next;
  logic [7:0]       out_byte, out_byte_next;
  logic             out_done, out_done_next;
  logic             out_err, out_err_next;
  logic             slot_free;

  assign slot_free          = !out_valid || cut_out.ready;
  assign cut_out.valid      = out_valid;
  assign cut_out.out_byte   = out_byte;
  assign cut_out.line_done  = out_done;
  assign cut_out.line_error = out_err;
  assign rd_en              = (state == S_READ);

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    idx_next       = idx;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    out_done_next  = out_done;
    out_err_next   = out_err;
    q_pop          = 1'b0;
    back_status    = '0;

    if (out_valid && cut_out.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_next = q_data;
          idx_next = '0;
          case (q_data.kind)
            CMD_BYTE:   state_next = S_ONE;
            CMD_CLOSE:  state_next = q_data.has_byte ? S_HELD : S_NL;
            CMD_REPLAY: state_next = (q_data.count == '0) ? S_NL : S_READ;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = cmd.data;
          out_done_next  = cmd.done;
          out_err_next   = cmd.err;
          state_next     = S_IDLE;
        end
      end
      S_HELD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = cmd.data;
          out_done_next  = 1'b0;
          out_err_next   = 1'b0;
          state_next     = S_NL;
        end
      end
      S_NL: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = NEWLINE_BYTE;
          out_done_next  = 1'b1;
          out_err_next   = 1'b0;
          state_next     = S_IDLE;
          back_status.replay_done = (cmd.kind == CMD_REPLAY);
        end
      end
      S_READ: begin
        state_next = S_RDATA;
      end
      S_RDATA: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = rd_data;
          out_done_next  = 1'b0;
          out_err_next   = 1'b0;
          idx_next       = idx + 1'b1;
          state_next     = (idx + 1'b1 == cmd.count) ? S_NL : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    out_byte <= out_byte_next;
    out_done <= out_done_next;
    out_err  <= out_err_next;
  end

endmodule

`default_nettype wire

/* rtl/core/delimited_field_cutter.sv */
// delimited_field_cutter: cuts selected characters or fields out of a byte stream of text.
// text_in carries one text byte per beat (10 ends a line); cut_out carries one result byte
// per beat with line_done on a line's closing newline and line_error on an overlong line.
// An APB port at byte addresses 0, 8, 16, 24 holds select_mask, separator, suppress_empty
// and by_character; write them only while the block is idle.
// The front end accepts a byte per cycle unless the queue is full or a replay is pending,
// and pushes at most one command per byte into a four-entry queue; the back end sends one
// beat for a byte command, any held byte and a newline for a close, and replays a whole
// line for a replay command. A selected byte is held until the next selected byte or the
// newline arrives, then passes through the queue, the back end's command register and the
// output register to cut_out. With every byte selected the back end sets the pace once the
// queue has filled; with few bytes selected text_in takes a byte per cycle while the queue
// has room and no replay is pending. A line with nothing selected and no suppression is
// replayed from the line store in field mode: each stored byte is read from the store's
// registered read port and then sent, the newline follows, and text_in is held off until
// the replay is finished. Reset empties the queue and the output register and clears the
// line state; the line store needs no clearing pass. When cut_out stalls, the output
// register holds its beat, the queue fills and text_in drops ready.
`timescale 1ns / 1ps
`default_nettype none

module delimited_field_cutter (
  input  wire          clk,
  input  wire          rst,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  dfc_byte_if.sink     text_in,
  dfc_cut_if.source    cut_out
);
  import dfc_pkg::*;

  cfg_t         cfg;
  logic         cfg_wr;
  logic [1:0]   reg_idx;
  logic         q_push, q_pop, q_full, q_empty;
  cmd_t         q_in, q_out;
  store_wr_t    store_wr;
  back_status_t back_status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_mask    <= '0;
      cfg.separator      <= TAB_BYTE;
      cfg.suppress_empty <= 1'b0;
      cfg.by_character   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SELECT_MASK:    cfg.select_mask    <= pwdata;
        REG_SEPARATOR:      cfg.separator      <= pwdata[7:0];
        REG_SUPPRESS_EMPTY: cfg.suppress_empty <= pwdata[0];
        REG_BY_CHARACTER:   cfg.by_character   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SELECT_MASK:    prdata = cfg.select_mask;
      REG_SEPARATOR:      prdata = {56'd0, cfg.separator};
      REG_SUPPRESS_EMPTY: prdata = {63'd0, cfg.suppress_empty};
      REG_BY_CHARACTER:   prdata = {63'd0, cfg.by_character};
      default:            prdata = '0;
    endcase
  end

  dfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .cfg         (cfg),
    .back_status (back_status),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in),
    .store_wr    (store_wr)
  );

  dfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  dfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .store_wr    (store_wr),
    .q_empty     (q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .back_status (back_status),
    .cut_out     (cut_out)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dfc_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_done;
    logic       line_error;
  } cut_beat_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  dfc_byte_if text_if ();
  dfc_cut_if  cut_if ();

  delimited_field_cutter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text_in (text_if),
    .cut_out (cut_if)
  );

  // predictor copy of the registers
  logic [63:0] cfg_mask;
  logic [7:0]  cfg_sep;
  logic        cfg_suppress;
  logic        cfg_by_char;

  // predictor copy of the line state
  logic [7:0]  line_buf [0:LINE_CHARS-1];
  int          line_len;
  logic [5:0]  field_num;
  logic [7:0]  held_char;
  logic        held_ok;
  logic        kept_any;
  logic        discard_rest;

  cut_beat_t   cut_exp_q [$];
  int          bad_beats;

  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int          rx_hold_cycles;

  always #10 clk = ~clk;

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void queue_beat(input logic [7:0] b, input logic done,
                                     input logic err);
    cut_beat_t beat;
    beat.out_byte   = b;
    beat.line_done  = done;
    beat.line_error = err;
    cut_exp_q.push_back(beat);
  endfunction

  function automatic void restart_line();
    line_len  = 0;
    field_num = '0;
    held_char = '0;
    held_ok   = 1'b0;
    kept_any  = 1'b0;
  endfunction

  // expected beats caused by one accepted text byte
  function automatic void cut_predict(input logic [7:0] b);
    int         i;
    logic [5:0] idx;
    if (discard_rest) begin
      if (b == NEWLINE_BYTE) discard_rest = 1'b0;
      return;
    end
    if (b == NEWLINE_BYTE) begin
      if (kept_any) begin
        // a separator still held at end of line is dropped
        if (held_ok && held_char != cfg_sep) queue_beat(held_char, 1'b0, 1'b0);
        queue_beat(NEWLINE_BYTE, 1'b1, 1'b0);
      end else if (!cfg_suppress && !cfg_by_char) begin
        for (i = 0; i < line_len; i++) queue_beat(line_buf[i], 1'b0, 1'b0);
        queue_beat(NEWLINE_BYTE, 1'b1, 1'b0);
      end
      restart_line();
      return;
    end
    if (line_len >= LINE_CHARS) begin
      queue_beat(8'h00, 1'b1, 1'b1);
      restart_line();
      discard_rest = 1'b1;
      return;
    end
    line_buf[line_len] = b;
    idx = cfg_by_char ? line_len[5:0] : field_num;
    if (cfg_mask[idx]) begin
      if (held_ok) queue_beat(held_char, 1'b0, 1'b0);
      held_char = b;
      held_ok   = 1'b1;
      kept_any  = 1'b1;
    end
    if (b == cfg_sep) field_num = field_num + 6'd1;
    line_len++;
  endfunction

  function automatic void check_cut_beat();
    cut_beat_t want;
    if (cut_exp_q.size() == 0) begin
      $display("%0t: unexpected beat out_byte %02h line_done %0b line_error %0b",
               $time, cut_if.out_byte, cut_if.line_done, cut_if.line_error);
      bad_beats++;
      return;
    end
    want = cut_exp_q.pop_front();
    if (cut_if.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %02h, actual %02h", $time, want.out_byte,
               cut_if.out_byte);
      bad_beats++;
    end
    if (cut_if.line_done !== want.line_done) begin
      $display("%0t: line_done expected %0b, actual %0b", $time, want.line_done,
               cut_if.line_done);
      bad_beats++;
    end
    if (cut_if.line_error !== want.line_error) begin
      $display("%0t: line_error expected %0b, actual %0b", $time, want.line_error,
               cut_if.line_error);
      bad_beats++;
    end
  endfunction

  // result side: random stalls, an optional long hold-off, check on every beat
  initial begin : cut_receiver
    int stall;
    forever begin
      if (rx_hold_cycles > 0) begin
        cut_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_stalls_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        cut_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cut_if.ready <= 1'b1;
      @(posedge clk);
      while (rst || cut_if.valid !== 1'b1) @(posedge clk);
      check_cut_beat();
    end
  end

  task automatic send_text_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid   <= 1'b1;
    text_if.in_byte <= b;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    cut_predict(b);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_text_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && cfg_sep != NEWLINE_BYTE) return cfg_sep;
    if (r < 9) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_non_newline();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NEWLINE_BYTE) b = 8'h0B;
    return b;
  endfunction

  task automatic send_random_line(input int len, output int sent);
    int i;
    for (i = 0; i < len; i++) send_text_byte(pick_text_byte());
    send_text_byte(NEWLINE_BYTE);
    sent = len + 1;
  endtask

  task automatic send_long_line(input int len);
    int i;
    for (i = 0; i < len; i++) send_text_byte(pick_non_newline());
    send_text_byte(NEWLINE_BYTE);
  endtask

  // stop sending, wait out every expected beat and any work left in the block
  task automatic drain();
    text_if.valid <= 1'b0;
    while (cut_exp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SELECT_MASK:    cfg_mask     = value;
      REG_SEPARATOR:      cfg_sep      = value[7:0];
      REG_SUPPRESS_EMPTY: cfg_suppress = value[0];
      REG_BY_CHARACTER:   cfg_by_char  = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] mask, input logic [7:0] sep,
                            input logic sup, input logic by_char);
    drain();
    write_reg(REG_SELECT_MASK, mask);
    write_reg(REG_SEPARATOR, {56'd0, sep});
    write_reg(REG_SUPPRESS_EMPTY, {63'd0, sup});
    write_reg(REG_BY_CHARACTER, {63'd0, by_char});
  endtask

  // mask 0 after reset: every line is replayed, the empty line too
  task automatic test_reset_defaults();
    send_text("a\tb\n");
    send_text("\n");
  endtask

  task automatic test_field_select();
    set_config(64'h5, 8'h2C, 1'b0, 1'b0);
    send_text("a,b,c\n");
    // field 0 ends with its separator, which is then dropped
    send_text("x,y\n");
    send_text_byte(8'h00);
    send_text_byte(8'hFF);
    send_text_byte(NEWLINE_BYTE);
  endtask

  task automatic test_replay_and_suppress();
    set_config(64'h20, 8'h2C, 1'b0, 1'b0);
    send_text("pq\n");
    set_config(64'h20, 8'h2C, 1'b1, 1'b0);
    send_text("pq\n");
  endtask

  task automatic test_by_character();
    set_config(64'h3, TAB_BYTE, 1'b0, 1'b1);
    send_text("abc\n");
    // character mode suppresses an empty line
    send_text("\n");
  endtask

  task automatic test_newline_separator();
    set_config(64'h1, NEWLINE_BYTE, 1'b0, 1'b0);
    send_text("a\n");
  endtask

  task automatic test_line_limit();
    set_config({$urandom, $urandom}, TAB_BYTE, 1'b0, 1'b0);
    send_long_line(LINE_CHARS);
    set_config({64{1'b1}}, TAB_BYTE, 1'b0, 1'b1);
    send_long_line(LINE_CHARS + 1);
    send_text("ok\n");
    set_config(64'h0, TAB_BYTE, 1'b0, 1'b0);
    send_long_line(LINE_CHARS + 1);
    send_text("ok\n");
  endtask

  task automatic test_random_lines();
    int          phase;
    int          items;
    int          sent;
    int          len;
    logic [63:0] mask;
    logic [7:0]  sep;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0:       mask = {64{1'b1}};
        1:       mask = 64'h0;
        2:       mask = 64'h1 << $urandom_range(0, 7);
        default: mask = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0:       sep = TAB_BYTE;
        1:       sep = 8'h2C;
        2:       sep = NEWLINE_BYTE;
        default: sep = 8'($urandom_range(0, 255));
      endcase
      if (phase == 0) begin
        mask = {64{1'b1}};
        sep  = 8'hFF;
      end else if (phase == 1) begin
        mask = 64'h0;
        sep  = 8'h00;
      end
      set_config(mask, sep, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      tx_gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      items = 0;
      while (items < 18) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
        send_random_line(len, sent);
        items += sent;
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    int sent;
    set_config({64{1'b1}}, 8'h2C, 1'b0, 1'b0);
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = 150;
    // every byte selected, so the queue fills while the receiver holds off
    for (i = 0; i < 40; i++) send_text_byte(pick_non_newline());
    send_text_byte(NEWLINE_BYTE);
    tx_gaps_on = 1'b1;
    drain();
    for (i = 0; i < 3; i++) send_random_line($urandom_range(2, 12), sent);
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    text_if.valid   = 1'b0;
    text_if.in_byte = 8'h00;
    tx_gaps_on      = 1'b1;
    rx_stalls_on    = 1'b1;
    rx_hold_cycles  = 0;
    bad_beats       = 0;
    cfg_mask        = 64'h0;
    cfg_sep         = TAB_BYTE;
    cfg_suppress    = 1'b0;
    cfg_by_char     = 1'b0;
    discard_rest    = 1'b0;
    restart_line();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_select();
    test_replay_and_suppress();
    test_by_character();
    test_newline_separator();
    test_random_lines();
    test_line_limit();
    test_backpressure();

    drain();
    if (bad_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
